/* design/chrl_pkg.sv */
// chrl_pkg: shared types, widths and codes for the hash ring lookup core
// used by chrl_cell and consistent_hash_ring_lookup_core; no dependencies

package chrl_pkg;

    // field widths fixed by the stream format
    localparam int KEY_W    = 32;
    localparam int OWNER_W  = 4;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    // default table size
    localparam int CAPACITY_DEF = 64;

    // stream word widths, padded to whole bytes
    localparam int IN_W  = 40;
    localparam int OUT_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic               cmp;
        logic               ins;
        logic               del;
        logic [KEY_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
    } cell_ctrl_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
        logic               valid;
        logic               lt;
        logic               gt;
    } cell_nbr_t;

endpackage

/* design/chrl_cell.sv */
// chrl_cell: one slot of the sorted ring table, with its compare flags
// depends on chrl_pkg for the control and neighbor structs

module chrl_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  chrl_pkg::cell_ctrl_t          ctrl,
    input  chrl_pkg::cell_nbr_t           left,
    input  chrl_pkg::cell_nbr_t           right,
    output chrl_pkg::cell_nbr_t           nbr,
    output logic                          eq,
    output logic                          hit,
    output logic [chrl_pkg::OWNER_W-1:0]  hit_owner
);

    logic [chrl_pkg::KEY_W-1:0]   key_reg,   key_next;
    logic [chrl_pkg::OWNER_W-1:0] owner_reg, owner_next;
    logic                         valid_reg, valid_next;
    logic                         lt_reg,    lt_next;
    logic                         eq_reg,    eq_next;
    logic                         gt_reg,    gt_next;

    // compare against the broadcast key, then shift toward a neighbor
    always_comb
    begin
        key_next   = key_reg;
        owner_next = owner_reg;
        valid_next = valid_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        gt_next    = gt_reg;
        if (ctrl.cmp)
        begin
            lt_next = valid_reg && (key_reg < ctrl.key);
            eq_next = valid_reg && (key_reg == ctrl.key);
            gt_next = valid_reg && (key_reg > ctrl.key);
        end
        else if (ctrl.ins && !lt_reg)
        begin
            // first slot not below the key takes the new entry, the rest move up
            if (left.lt)
            begin
                key_next   = ctrl.key;
                owner_next = ctrl.owner;
                valid_next = 1'b1;
            end
            else
            begin
                key_next   = left.key;
                owner_next = left.owner;
                valid_next = left.valid;
            end
        end
        else if (ctrl.del && !lt_reg)
        begin
            // matching slot and all above take their right neighbor
            key_next   = right.key;
            owner_next = right.owner;
            valid_next = right.valid;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            gt_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
            gt_reg    <= gt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        owner_reg <= owner_next;
    end

    // neighbor view and lookup hit (first slot above the key)
    assign nbr.key   = key_reg;
    assign nbr.owner = owner_reg;
    assign nbr.valid = valid_reg;
    assign nbr.lt    = lt_reg;
    assign nbr.gt    = gt_reg;
    assign eq        = eq_reg;
    assign hit       = gt_reg && !left.gt;
    assign hit_owner = hit ? owner_reg : '0;

endmodule

/* design/consistent_hash_ring_lookup_core.sv */
// consistent_hash_ring_lookup_core: top level of the hash ring lookup block
// depends on chrl_pkg and chrl_cell
//
// Usage: commands arrive on the s_ stream (insert, delete, lookup), one
// result per transaction leaves on the m_ stream. The ring is a chain of
// CAPACITY cells kept sorted ascending; each cell holds one key, its owner
// and a valid bit, and talks only to its two neighbors.
// Sequence: the core takes one transaction at a time. In the accept cycle all
// cells compare their key with the request key in parallel; in the execute
// state the sequencer reads the registered flags, the cells shift one place
// for insert or delete, and the result goes into the output register.
// A new transaction is taken only once the sequencer is back in idle, while
// the result may still wait in the output register.
// Reset: all cells become empty, the output register is emptied.
// Stall: if the receiver holds m_tready low and a result is still waiting,
// the sequencer holds in its execute state and the table is left untouched
// until the output register frees; s_tready stays low meanwhile.

module consistent_hash_ring_lookup_core
#(
    parameter int CAPACITY = chrl_pkg::CAPACITY_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // cmd [1:0], key [33:2], owner_id [37:34], zero [39:38]
    input  logic [chrl_pkg::IN_W-1:0]  s_tdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // owner_found [3:0], status [6:4], zero [7]
    output logic [chrl_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                            state_reg, state_next;
    logic [chrl_pkg::CMD_W-1:0]      cmd_reg,   cmd_next;
    logic [chrl_pkg::KEY_W-1:0]      key_reg,   key_next;
    logic [chrl_pkg::OWNER_W-1:0]    own_reg,   own_next;
    logic                            out_valid_reg, out_valid_next;
    logic [chrl_pkg::OWNER_W-1:0]    found_reg, found_next;
    logic [chrl_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                            in_fire;
    logic                            exec_fire;
    logic                            any_eq;
    logic                            any_hit;
    logic [chrl_pkg::OWNER_W-1:0]    hit_owner_or;
    logic                            ins_en;
    logic                            del_en;
    logic [CAPACITY-1:0]             valid_vec;

    chrl_pkg::cell_ctrl_t            ctrl;
    chrl_pkg::cell_nbr_t             cell_out  [CAPACITY];
    chrl_pkg::cell_nbr_t             left_in   [CAPACITY];
    chrl_pkg::cell_nbr_t             right_in  [CAPACITY];
    logic [CAPACITY-1:0]             eq_vec;
    logic [CAPACITY-1:0]             hit_vec;
    logic [chrl_pkg::OWNER_W-1:0]    hit_own   [CAPACITY];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    // cell control broadcast: compare uses the live input key
    assign ctrl.cmp   = in_fire;
    assign ctrl.ins   = ins_en;
    assign ctrl.del   = del_en;
    assign ctrl.key   = (state_reg == ST_IDLE) ? s_tdata[33:2] : key_reg;
    assign ctrl.owner = own_reg;

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_in[i] = '{key: '0, owner: '0, valid: 1'b1, lt: 1'b1, gt: 1'b0};
        end
        else
        begin : g_mid_l
            assign left_in[i] = cell_out[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in[i] = '{key: '0, owner: '0, valid: 1'b0, lt: 1'b0, gt: 1'b0};
        end
        else
        begin : g_mid_r
            assign right_in[i] = cell_out[i+1];
        end

        chrl_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left      (left_in[i]),
            .right     (right_in[i]),
            .nbr       (cell_out[i]),
            .eq        (eq_vec[i]),
            .hit       (hit_vec[i]),
            .hit_owner (hit_own[i])
        );

        assign valid_vec[i] = cell_out[i].valid;
    end

    // gather registered flags from all cells
    always_comb
    begin
        hit_owner_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_owner_or = hit_owner_or | hit_own[i];
        end
    end
    assign any_eq  = |eq_vec;
    assign any_hit = |hit_vec;

    // table updates in the execute state
    assign ins_en = exec_fire && (cmd_reg == chrl_pkg::CMD_INSERT) && !any_eq
                    && !valid_vec[CAPACITY-1];
    assign del_en = exec_fire && (cmd_reg == chrl_pkg::CMD_DELETE) && any_eq;

    // sequencer and result
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        own_next       = own_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = s_tdata[1:0];
                    key_next   = s_tdata[33:2];
                    own_next   = s_tdata[37:34];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    out_valid_next = 1'b1;
                    found_next     = '0;
                    status_next    = chrl_pkg::ST_DONE;
                    case (cmd_reg)
                        chrl_pkg::CMD_INSERT:
                        begin
                            if (any_eq)
                                status_next = chrl_pkg::ST_DUP;
                            else if (valid_vec[CAPACITY-1])
                                status_next = chrl_pkg::ST_FULL;
                        end
                        chrl_pkg::CMD_DELETE:
                        begin
                            if (!any_eq)
                                status_next = chrl_pkg::ST_ABSENT;
                        end
                        chrl_pkg::CMD_LOOKUP:
                        begin
                            if (!valid_vec[0])
                                status_next = chrl_pkg::ST_EMPTY;
                            else if (any_hit)
                                found_next = hit_owner_or;
                            else
                                found_next = cell_out[0].owner;
                        end
                        default:
                        begin
                            status_next = chrl_pkg::ST_DONE;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // held transaction and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        own_reg    <= own_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, status_reg, found_reg};

    // occupied cells always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("occupied cells are not a prefix");

    // an accepted transaction moves the sequencer to its execute state
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_EXEC)
        else $error("accept not followed by execute");

    // a result only appears out of the execute cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EXEC)
        else $error("result without execute");

    // insert grows the table by one entry
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
        else $error("insert did not add one entry");

    // delete shrinks the table by one entry
    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        del_en |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
        else $error("delete did not remove one entry");

endmodule

/* test/consistent_hash_ring_lookup_core_test.sv */
// consistent_hash_ring_lookup_core_test: self-checking bench for the hash ring lookup core
// drives insert, delete and lookup commands with random stalls and checks every result
// depends on chrl_pkg and consistent_hash_ring_lookup_core
`timescale 1ns / 100ps

module consistent_hash_ring_lookup_core_test;

    localparam int RING_DEPTH  = chrl_pkg::CAPACITY_DEF;
    localparam int POOL_SIZE   = 128;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    typedef logic [chrl_pkg::OWNER_W-1:0]  owner_t;
    typedef logic [$clog2(POOL_SIZE)-1:0]  pool_idx_t;

    typedef struct {
        logic [chrl_pkg::OWNER_W-1:0]  owner_found;
        logic [chrl_pkg::STATUS_W-1:0] status;
    } ring_result_t;

    // sorted ring table mirror and the queue of results still owed by the core
    class ring_scoreboard;
        logic [chrl_pkg::KEY_W-1:0]   ring_key [RING_DEPTH];
        logic [chrl_pkg::OWNER_W-1:0] ring_own [RING_DEPTH];
        int                           ring_size;
        ring_result_t                 owed_results [$];
        int                           error_count;

        function new();
            ring_size   = 0;
            error_count = 0;
        endfunction

        // apply one accepted command to the mirror and queue its result
        function void note_command(logic [chrl_pkg::CMD_W-1:0] cmd,
                                   logic [chrl_pkg::KEY_W-1:0] key,
                                   logic [chrl_pkg::OWNER_W-1:0] owner);
            ring_result_t res;
            int           pos;
            int           i;
            res.owner_found = '0;
            res.status      = chrl_pkg::ST_DONE;
            // first slot whose key is not below the request key
            pos = 0;
            while (pos < ring_size && ring_key[pos] < key)
                pos++;
            case (cmd)
                chrl_pkg::CMD_INSERT:
                begin
                    if (pos < ring_size && ring_key[pos] == key)
                        res.status = chrl_pkg::ST_DUP;
                    else if (ring_size >= RING_DEPTH)
                        res.status = chrl_pkg::ST_FULL;
                    else
                    begin
                        for (i = ring_size; i > pos; i--)
                        begin
                            ring_key[i] = ring_key[i-1];
                            ring_own[i] = ring_own[i-1];
                        end
                        ring_key[pos] = key;
                        ring_own[pos] = owner;
                        ring_size++;
                    end
                end
                chrl_pkg::CMD_DELETE:
                begin
                    if (pos < ring_size && ring_key[pos] == key)
                    begin
                        for (i = pos; i < ring_size - 1; i++)
                        begin
                            ring_key[i] = ring_key[i+1];
                            ring_own[i] = ring_own[i+1];
                        end
                        ring_size--;
                    end
                    else
                        res.status = chrl_pkg::ST_ABSENT;
                end
                chrl_pkg::CMD_LOOKUP:
                begin
                    if (ring_size == 0)
                        res.status = chrl_pkg::ST_EMPTY;
                    else
                    begin
                        // successor is strictly greater, wrap to the smallest key
                        while (pos < ring_size && ring_key[pos] <= key)
                            pos++;
                        if (pos >= ring_size)
                            pos = 0;
                        res.owner_found = ring_own[pos];
                    end
                end
                default:
                    ;
            endcase
            owed_results.push_back(res);
        endfunction

        // compare one result word with the oldest owed result
        function void check_result(logic [chrl_pkg::OUT_W-1:0] word);
            ring_result_t owed;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual owner %0d status %0d",
                         $time, word[3:0], word[6:4]);
                error_count++;
                return;
            end
            owed = owed_results.pop_front();
            if (word[3:0] !== owed.owner_found)
            begin
                $display("%0t: owner_found mismatch, expected %0d actual %0d",
                         $time, owed.owner_found, word[3:0]);
                error_count++;
            end
            if (word[6:4] !== owed.status)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, owed.status, word[6:4]);
                error_count++;
            end
        endfunction
    endclass

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    // cmd [1:0], key [33:2], owner_id [37:34], zero [39:38]
    logic [chrl_pkg::IN_W-1:0]      s_tdata  = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // owner_found [3:0], status [6:4], zero [7]
    logic [chrl_pkg::OUT_W-1:0]     m_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;

    ring_scoreboard                 sb = new();
    logic [chrl_pkg::KEY_W-1:0]     key_pool [POOL_SIZE];
    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    int                             hold_requests = 0;
    int                             hold_served   = 0;
    int                             hold_left     = 0;
    int                             cycle_count   = 0;
    bit                             shrinking     = 1'b0;

    consistent_hash_ring_lookup_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check each transaction, then pick tready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one command and wait for its transaction
    task automatic send_command(input logic [chrl_pkg::CMD_W-1:0] cmd,
                                input logic [chrl_pkg::KEY_W-1:0] key,
                                input logic [chrl_pkg::OWNER_W-1:0] owner);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, owner, key, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_command(cmd, key, owner);
    endtask

    // stop offering until every owed result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.owed_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [chrl_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(4) == 0)
            return $urandom();
        return key_pool[pool_idx_t'($urandom_range(POOL_SIZE - 1))];
    endfunction

    // random mix: grows the ring until it is full, then drains it to empty
    task automatic run_random(input int count);
        int                           roll;
        logic [chrl_pkg::CMD_W-1:0]   cmd;
        logic [chrl_pkg::KEY_W-1:0]   key;
        repeat (count)
        begin
            if (sb.ring_size == RING_DEPTH && $urandom_range(7) == 0)
                shrinking = 1'b1;
            if (sb.ring_size == 0)
                shrinking = 1'b0;
            roll = $urandom_range(99);
            if (roll < 3)
                cmd = chrl_pkg::CMD_NOP;
            else if (roll < (shrinking ? 15 : 70))
                cmd = chrl_pkg::CMD_INSERT;
            else if (roll < (shrinking ? 75 : 80))
                cmd = chrl_pkg::CMD_DELETE;
            else
                cmd = chrl_pkg::CMD_LOOKUP;
            key = pick_key();
            // lookups also probe just around stored keys
            if (cmd == chrl_pkg::CMD_LOOKUP)
            begin
                case ($urandom_range(3))
                    0: key = key + 1;
                    1: key = key - 1;
                    default: ;
                endcase
            end
            send_command(cmd, key, owner_t'($urandom_range(15)));
        end
    endtask

    // stimulus
    initial
    begin
        int base;
        // key pool: extremes, a tight cluster, and spread values
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h0000_0001;
        key_pool[3] = 32'hFFFF_FFFE;
        base = $urandom();
        for (int i = 4; i < 32; i++)
            key_pool[i] = base + i;
        for (int i = 32; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, wrap, absent keys
        send_command(chrl_pkg::CMD_LOOKUP, 32'h0000_0000, 4'd0);
        send_command(chrl_pkg::CMD_DELETE, 32'h0000_0005, 4'd0);
        send_command(chrl_pkg::CMD_NOP,    32'hFFFF_FFFF, 4'd15);
        send_command(chrl_pkg::CMD_INSERT, 32'h0000_0000, 4'd0);
        send_command(chrl_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'd15);
        send_command(chrl_pkg::CMD_INSERT, 32'h8000_0000, 4'd7);
        send_command(chrl_pkg::CMD_INSERT, 32'h0000_0000, 4'd9);
        send_command(chrl_pkg::CMD_LOOKUP, 32'h0000_0000, 4'd0);
        send_command(chrl_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 4'd0);
        send_command(chrl_pkg::CMD_LOOKUP, 32'h8000_0000, 4'd0);
        send_command(chrl_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 4'd0);
        send_command(chrl_pkg::CMD_DELETE, 32'h8000_0000, 4'd3);
        send_command(chrl_pkg::CMD_DELETE, 32'h8000_0000, 4'd3);
        send_command(chrl_pkg::CMD_LOOKUP, 32'h0000_0000, 4'd0);
        send_command(chrl_pkg::CMD_INSERT, 32'h5555_5555, 4'd10);
        send_command(chrl_pkg::CMD_INSERT, 32'hAAAA_AAAA, 4'd5);
        send_command(chrl_pkg::CMD_LOOKUP, 32'h5555_5554, 4'd0);
        send_command(chrl_pkg::CMD_LOOKUP, 32'h5555_5555, 4'd0);
        send_command(chrl_pkg::CMD_DELETE, 32'h0000_0000, 4'd0);
        send_command(chrl_pkg::CMD_DELETE, 32'hFFFF_FFFF, 4'd0);
        send_command(chrl_pkg::CMD_DELETE, 32'h5555_5555, 4'd0);
        send_command(chrl_pkg::CMD_DELETE, 32'hAAAA_AAAA, 4'd0);
        send_command(chrl_pkg::CMD_LOOKUP, 32'h1234_5678, 4'd0);
        send_command(chrl_pkg::CMD_NOP,    32'h0000_0000, 4'd0);
        wait_drain();

        // sender rarely idles, receiver mostly stalls
        send_idle_pct = 6;
        recv_idle_pct = 84;
        run_random(265);
        wait_drain();

        // sender mostly idles, receiver rarely stalls
        send_idle_pct = 84;
        recv_idle_pct = 6;
        run_random(130);
        wait_drain();
        run_random(135);
        wait_drain();

        // full rate, with one long receiver hold-off while commands keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(60);
        hold_requests = hold_requests + 1;
        run_random(205);
        wait_drain();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.error_count == 0 && sb.owed_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
